### rtl/core/ffha_pkg.sv
// Shared constants, types and helpers for the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 32;

  localparam int unsigned VW = 26;                // offset and length width
  localparam logic [VW-1:0] HEAP_MIN = 26'd64;
  localparam logic [VW-1:0] HEAP_MAX = 26'd33554432;

  // Transaction kinds on in_tuser
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_REL = 2'd2;

  // One table entry: start offset and length including header
  typedef struct packed {
    logic [VW-1:0] start;
    logic [VW-1:0] len;
  } entry_t;

  // Clamp a written arena size into the legal range
  function automatic logic [VW-1:0] clamp_heap(input logic [VW-1:0] v);
    logic [VW-1:0] r;
    r = v;
    if (v < HEAP_MIN) r = HEAP_MIN;
    if (v > HEAP_MAX) r = HEAP_MAX;
    return r;
  endfunction

endpackage

### rtl/core/ffha_table.sv
// Block table storage: single write port, one registered read port.
module ffha_table #(
  parameter int unsigned DEPTH = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output ffha_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  ffha_pkg::entry_t     wr_data
);

  ffha_pkg::entry_t mem [DEPTH];
  ffha_pkg::entry_t rd_data_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/first_fit_heap_allocator_top.sv
// First-fit heap allocator top level: sequencer, in-use flags and result register.
//
// The arena is kept as an address-ordered table of up to MAX_BLOCKS blocks in a
// memory with one write port and one registered read port, so every table
// access takes a read state and then an evaluate or write state. An allocate
// scans entries and moves entries on a split; a release scans entries and
// moves entries for each merge, up to two merges. One transaction is worked
// at a time; in_tready is high only when the sequencer is idle, and a
// finished result waits in the output register while the next transaction
// is taken. After reset and after each heap_bytes write the table is rebuilt
// to one free block in the init state, during which nothing is accepted.
module first_fit_heap_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: heap_bytes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [25:0] cfg_data,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [25:0] request_size, [51:26] release_offset, rest zero
  input  logic        in_tuser,   // [0] kind
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [27:2] payload_offset, rest zero
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned VW = ffha_pkg::VW;
  localparam logic [VW:0]  HDR = (VW+1)'(HEADER_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_EV = 4'd3;
  localparam logic [3:0] S_INS_RD  = 4'd4;
  localparam logic [3:0] S_INS_WR  = 4'd5;
  localparam logic [3:0] S_PREV_RD = 4'd6;
  localparam logic [3:0] S_PREV_EV = 4'd7;
  localparam logic [3:0] S_DEL_RD  = 4'd8;
  localparam logic [3:0] S_DEL_WR  = 4'd9;
  localparam logic [3:0] S_NEXT_RD = 4'd10;
  localparam logic [3:0] S_NEXT_EV = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  // control state
  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [MAX_BLOCKS-1:0] in_use_r, in_use_nxt;
  logic [VW-1:0]         heap_r, heap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  phase_r, phase_nxt;

  // working registers
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [CW-1:0]         f_r, f_nxt;
  logic                  kind_r, kind_nxt;
  logic [VW-1:0]         off_r, off_nxt;
  logic [VW:0]           need_r, need_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [VW-1:0]         payload_r, payload_nxt;
  logic [VW-1:0]         cur_start_r, cur_start_nxt;
  logic [VW-1:0]         cur_len_r, cur_len_nxt;
  ffha_pkg::entry_t      new_r, new_nxt;
  logic [31:0]           out_data_r, out_data_nxt;

  // table port
  logic                  rd_en, wr_en;
  logic [IW-1:0]         rd_addr, wr_addr;
  ffha_pkg::entry_t      rd_data, wr_data;

  // shifted in-use vectors
  logic [MAX_BLOCKS-1:0] ins_vec, del_vec;
  logic [CW-1:0]         del_pos;
  logic [VW:0]           e_pay;
  logic                  e_free;

  ffha_table #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign e_pay  = {1'b0, rd_data.start} + HDR;
  assign e_free = !in_use_r[idx_r[IW-1:0]];
  assign del_pos = (state_r == S_PREV_EV) ? f_r : f_r + CNT_ONE;

  // Open a free slot after idx and mark idx used; close the slot at del_pos
  always_comb begin
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (CW'(k) > idx_r + CNT_ONE) begin
        ins_vec[k] = (k > 0) ? in_use_r[(k + MAX_BLOCKS - 1) % MAX_BLOCKS] : 1'b0;
      end else if (CW'(k) == idx_r + CNT_ONE) begin
        ins_vec[k] = 1'b0;
      end else if (CW'(k) == idx_r) begin
        ins_vec[k] = 1'b1;
      end else begin
        ins_vec[k] = in_use_r[k];
      end
      if (CW'(k) >= del_pos) begin
        del_vec[k] = (k + 1 < MAX_BLOCKS) ? in_use_r[(k+1) % MAX_BLOCKS] : 1'b0;
      end else begin
        del_vec[k] = in_use_r[k];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    in_use_nxt    = in_use_r;
    heap_nxt      = heap_r;
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    f_nxt         = f_r;
    kind_nxt      = kind_r;
    off_nxt       = off_r;
    need_nxt      = need_r;
    status_nxt    = status_r;
    payload_nxt   = payload_r;
    cur_start_nxt = cur_start_r;
    cur_len_nxt   = cur_len_r;
    new_nxt       = new_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;

    // drop result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        wr_en         = 1'b1;
        wr_data.start = '0;
        wr_data.len   = heap_r;
        count_nxt     = CNT_ONE;
        in_use_nxt    = '0;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          heap_nxt  = ffha_pkg::clamp_heap(cfg_data);
          state_nxt = S_INIT;
        end else if (in_tvalid) begin
          kind_nxt    = in_tuser;
          off_nxt     = in_tdata[51:26];
          need_nxt    = {1'b0, in_tdata[25:0]} + HDR;
          idx_nxt     = '0;
          payload_nxt = '0;
          if (in_tuser == ffha_pkg::KIND_ALLOC && in_tdata[25:0] == '0) begin
            status_nxt = ffha_pkg::ST_NO_FIT;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == count_r) begin
          status_nxt = (kind_r == ffha_pkg::KIND_RELEASE) ? ffha_pkg::ST_BAD_REL
                                                          : ffha_pkg::ST_NO_FIT;
          state_nxt  = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r[IW-1:0];
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (kind_r == ffha_pkg::KIND_ALLOC) begin
          if (e_free && {1'b0, rd_data.len} > need_r) begin
            status_nxt  = ffha_pkg::ST_OK;
            payload_nxt = e_pay[VW-1:0];
            if ({1'b0, rd_data.len} > need_r + HDR && count_r < CNT_MAX) begin
              // split: shrink this entry, queue the remainder behind it
              wr_en         = 1'b1;
              wr_addr       = idx_r[IW-1:0];
              wr_data.start = rd_data.start;
              wr_data.len   = need_r[VW-1:0];
              new_nxt.start = rd_data.start + need_r[VW-1:0];
              new_nxt.len   = rd_data.len - need_r[VW-1:0];
              in_use_nxt    = ins_vec;
              count_nxt     = count_r + CNT_ONE;
              k_nxt         = count_r;
              state_nxt     = S_INS_RD;
            end else begin
              in_use_nxt[idx_r[IW-1:0]] = 1'b1;
              state_nxt = S_RESP;
            end
          end else begin
            idx_nxt   = idx_r + CNT_ONE;
            state_nxt = S_SCAN_RD;
          end
        end else begin
          if (e_pay == {1'b0, off_r}) begin
            if (e_free) begin
              status_nxt = ffha_pkg::ST_BAD_REL;
              state_nxt  = S_RESP;
            end else begin
              status_nxt    = ffha_pkg::ST_OK;
              in_use_nxt[idx_r[IW-1:0]] = 1'b0;
              f_nxt         = idx_r;
              cur_start_nxt = rd_data.start;
              cur_len_nxt   = rd_data.len;
              state_nxt     = S_PREV_RD;
            end
          end else begin
            idx_nxt   = idx_r + CNT_ONE;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_INS_RD: begin
        if (k_r == idx_r + CNT_ONE) begin
          wr_en     = 1'b1;
          wr_addr   = k_r[IW-1:0];
          wr_data   = new_r;
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = IW'(k_r - CNT_ONE);
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[IW-1:0];
        wr_data   = rd_data;
        k_nxt     = k_r - CNT_ONE;
        state_nxt = S_INS_RD;
      end
      S_PREV_RD: begin
        if (f_r != '0 && !in_use_r[IW'(f_r - CNT_ONE)]) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(f_r - CNT_ONE);
          state_nxt = S_PREV_EV;
        end else begin
          state_nxt = S_NEXT_RD;
        end
      end
      S_PREV_EV: begin
        // fold into the free block before, then remove this entry
        wr_en         = 1'b1;
        wr_addr       = IW'(f_r - CNT_ONE);
        wr_data.start = rd_data.start;
        wr_data.len   = rd_data.len + cur_len_r;
        cur_start_nxt = rd_data.start;
        cur_len_nxt   = rd_data.len + cur_len_r;
        in_use_nxt    = del_vec;
        k_nxt         = f_r;
        f_nxt         = f_r - CNT_ONE;
        phase_nxt     = 1'b0;
        state_nxt     = S_DEL_RD;
      end
      S_DEL_RD: begin
        if (k_r + CNT_ONE == count_r) begin
          count_nxt = count_r - CNT_ONE;
          state_nxt = phase_r ? S_RESP : S_NEXT_RD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = IW'(k_r + CNT_ONE);
          state_nxt = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        wr_en     = 1'b1;
        wr_addr   = k_r[IW-1:0];
        wr_data   = rd_data;
        k_nxt     = k_r + CNT_ONE;
        state_nxt = S_DEL_RD;
      end
      S_NEXT_RD: begin
        if (f_r + CNT_ONE < count_r && !in_use_r[IW'(f_r + CNT_ONE)]) begin
          rd_en     = 1'b1;
          rd_addr   = IW'(f_r + CNT_ONE);
          state_nxt = S_NEXT_EV;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_NEXT_EV: begin
        // absorb the free block after, then remove it
        wr_en         = 1'b1;
        wr_addr       = f_r[IW-1:0];
        wr_data.start = cur_start_r;
        wr_data.len   = cur_len_r + rd_data.len;
        in_use_nxt    = del_vec;
        k_nxt         = f_r + CNT_ONE;
        phase_nxt     = 1'b1;
        state_nxt     = S_DEL_RD;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, payload_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_ONE;
      in_use_r    <= '0;
      heap_r      <= ffha_pkg::HEAP_MAX;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      heap_r      <= heap_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    f_r         <= f_nxt;
    kind_r      <= kind_nxt;
    off_r       <= off_nxt;
    need_r      <= need_nxt;
    status_r    <= status_nxt;
    payload_r   <= payload_nxt;
    cur_start_r <= cur_start_nxt;
    cur_len_r   <= cur_len_nxt;
    new_r       <= new_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

### rtl/core/ffha_checker.sv
// Port-level checks for the first-fit heap allocator, bound to the top level.
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Go busy after each accepted transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second transaction while busy");

  // Status is one of the defined codes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  // Failed results carry no offset
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ffha_pkg::ST_OK |-> out_tdata[27:2] == 26'd0)
    else $error("failed result with nonzero offset");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/heap_result_checker.sv
// Checker for the heap allocator: mirrors the block table, predicts and compares results.
module heap_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [25:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count,
  output int          grant_count
);

  localparam int NBLK = ffha_pkg::MAX_BLOCKS_DEF;
  localparam int HDR  = ffha_pkg::HEADER_BYTES_DEF;
  localparam int VW   = ffha_pkg::VW;

  typedef struct packed {
    logic [1:0]    status;
    logic [VW-1:0] payload;
  } answer_t;

  answer_t          answer_q[$];
  logic [VW-1:0]    arena_bytes;
  longint unsigned  blk_start[NBLK];
  longint unsigned  blk_len[NBLK];
  bit               blk_used[NBLK];
  int               blk_count;

  // Reset the mirror table to one free block covering the arena
  function automatic void rebuild_table();
    for (int k = 0; k < NBLK; k++) begin
      blk_start[k] = 0;
      blk_len[k]   = 0;
      blk_used[k]  = 0;
    end
    blk_len[0] = arena_bytes;
    blk_count  = 1;
  endfunction

  function automatic void open_slot(int pos);
    for (int k = blk_count; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_len[k]   = blk_len[k-1];
      blk_used[k]  = blk_used[k-1];
    end
    blk_count++;
  endfunction

  function automatic void drop_slot(int pos);
    for (int k = pos; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_len[k]   = blk_len[k+1];
      blk_used[k]  = blk_used[k+1];
    end
    blk_count--;
  endfunction

  // First-fit allocate with split
  function automatic answer_t predict_alloc(logic [VW-1:0] size);
    answer_t         a;
    longint unsigned need;
    need = longint'(size) + HDR;
    a.status  = ffha_pkg::ST_NO_FIT;
    a.payload = '0;
    if (size == 0) return a;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_used[i] || blk_len[i] <= need) continue;
      if (blk_len[i] > need + HDR && blk_count < NBLK) begin
        open_slot(i + 1);
        blk_start[i+1] = blk_start[i] + need;
        blk_len[i+1]   = blk_len[i] - need;
        blk_used[i+1]  = 0;
        blk_len[i]     = need;
      end
      blk_used[i] = 1;
      a.status  = ffha_pkg::ST_OK;
      a.payload = VW'(blk_start[i] + HDR);
      return a;
    end
    return a;
  endfunction

  // Release with merge on both sides
  function automatic answer_t predict_release(logic [VW-1:0] off);
    answer_t a;
    int      hit;
    hit = -1;
    a.payload = '0;
    for (int i = 0; i < blk_count; i++)
      if (blk_start[i] + HDR == off) begin
        hit = i;
        break;
      end
    if (hit < 0 || !blk_used[hit]) begin
      a.status = ffha_pkg::ST_BAD_REL;
      return a;
    end
    a.status = ffha_pkg::ST_OK;
    blk_used[hit] = 0;
    if (hit > 0 && !blk_used[hit-1]) begin
      blk_len[hit-1] += blk_len[hit];
      drop_slot(hit);
      hit--;
    end
    if (hit + 1 < blk_count && !blk_used[hit+1]) begin
      blk_len[hit] += blk_len[hit+1];
      drop_slot(hit + 1);
    end
    return a;
  endfunction

  assign pending_count = answer_q.size();

  always @(posedge clk) begin
    answer_t exp_a;
    logic [25:0] v;
    if (!rst_n) begin
      arena_bytes = ffha_pkg::HEAP_MAX;
      rebuild_table();
      answer_q.delete();
      fail_count   <= 0;
      result_count <= 0;
      grant_count  <= 0;
    end else begin
      // Register write: clamp and rebuild
      if (cfg_valid && cfg_ready) begin
        v = cfg_data;
        if (v < ffha_pkg::HEAP_MIN) v = ffha_pkg::HEAP_MIN;
        if (v > ffha_pkg::HEAP_MAX) v = ffha_pkg::HEAP_MAX;
        arena_bytes = v;
        rebuild_table();
      end
      // Request transaction: predict
      if (in_tvalid && in_tready) begin
        if (in_tuser == ffha_pkg::KIND_RELEASE)
          answer_q.push_back(predict_release(in_tdata[51:26]));
        else answer_q.push_back(predict_alloc(in_tdata[25:0]));
      end
      // Result transaction: compare with oldest
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (answer_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answer_q.pop_front();
          if (exp_a.status == ffha_pkg::ST_OK && exp_a.payload != 0)
            grant_count <= grant_count + 1;
          if (out_tdata[1:0] != exp_a.status) begin
            $error("status: expected %0d actual %0d", exp_a.status, out_tdata[1:0]);
            fail_count <= fail_count + 1;
          end else if (out_tdata[27:2] != exp_a.payload) begin
            $error("payload_offset: expected %0d actual %0d", exp_a.payload, out_tdata[27:2]);
            fail_count <= fail_count + 1;
          end else if (out_tdata[31:28] != 0) begin
            $error("pad: expected 0 actual %0h", out_tdata[31:28]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### test/first_fit_heap_allocator_top_test.sv
// Testbench top for the heap allocator: stimulus, idling, verdict.
module first_fit_heap_allocator_top_test;

  localparam int LIMIT = 2000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [25:0] cfg_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // [25:0] request_size, [51:26] release_offset
  logic        in_tuser = 0;    // [0] kind
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;       // [1:0] status, [27:2] payload_offset
  int          fail_count, pending_count, result_count, grant_count;
  int          cycle_count = 0;
  int          sent_count = 0;
  logic [25:0] granted_q[$];
  bit          no_stall = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  first_fit_heap_allocator_top i_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  heap_result_checker i_checker (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending_count, .result_count, .grant_count
  );

  // Watch results to learn granted offsets for well-formed releases
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready && out_tdata[1:0] == ffha_pkg::ST_OK
        && out_tdata[27:2] != 0)
      granted_q.push_back(out_tdata[27:2]);

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random receiver stall
  always @(posedge clk) begin
    if (no_stall) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 99) < 70);
  end

  // Keep valid up through a zero gap; drop it only for a real gap
  task automatic send_item(logic kind, logic [25:0] size, logic [25:0] off);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, off, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic alloc(logic [25:0] size);
    send_item(ffha_pkg::KIND_ALLOC, size, 26'($urandom));
  endtask

  task automatic release_at(logic [25:0] off);
    send_item(ffha_pkg::KIND_RELEASE, 26'($urandom), off);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_heap(logic [25:0] v);
    drain();
    granted_q.delete();
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Release a random earlier grant (possibly a stale one)
  task automatic release_some();
    int idx;
    if (granted_q.size() == 0) begin
      release_at(26'($urandom_range(0, 4096)));
      return;
    end
    idx = $urandom_range(0, granted_q.size() - 1);
    release_at(granted_q[idx]);
    if ($urandom_range(0, 3) != 0) granted_q.delete(idx);
  endtask

  task automatic random_phase(int n, int max_size);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) alloc(26'($urandom_range(1, max_size)));
      else if (r < 85) release_some();
      else if (r < 90) alloc(26'd0);
      else if (r < 95) release_at(26'($urandom));
      else alloc(26'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    // Directed: extremes, zero size, no fit, bad releases, merges
    alloc(26'd0);
    alloc(26'h3FF_FFFF);
    alloc(ffha_pkg::HEAP_MAX - 26'd33);
    release_at(26'd32);
    release_at(26'd0);
    release_at(26'h3FF_FFFF);
    alloc(26'd1);
    alloc(26'd100);
    alloc(26'd1);
    release_at(26'd32);
    release_at(26'd32);
    alloc(26'd1);
    release_at(26'd64);
    drain();
    while (granted_q.size() != 0) release_at(granted_q.pop_front());

    // Smallest arena: whole-block grant without split, then no fit
    write_heap(26'd0);
    alloc(26'd1);
    alloc(26'd1);
    release_at(26'd32);
    alloc(26'd31);
    write_heap(26'd96);
    alloc(26'd1);
    alloc(26'd1);
    alloc(26'd1);
    write_heap(26'h3FF_FFFF);
    alloc(ffha_pkg::HEAP_MAX - 26'd33);
    release_at(26'd32);

    // Fill the table to exercise the full-table grant
    write_heap(26'd8192);
    repeat (70) alloc(26'($urandom_range(1, 40)));
    random_phase(60, 200);

    // Random phases across several arena sizes
    write_heap(26'd2048);
    random_phase(150, 120);
    write_heap(26'($urandom_range(64, 100000)));
    random_phase(150, 3000);
    no_stall = 1;
    random_phase(40, 64);
    no_stall = 0;
    write_heap(ffha_pkg::HEAP_MAX);
    random_phase(150, 1 << 20);

    drain();
    $display("Sent %0d requests, checked %0d results, %0d grants",
             sent_count, result_count, grant_count);
    $display("Arena sizes covered: min clamp, small, random and max clamp");
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
